FILE: sv/mmrd_pkg.sv
// constants, status codes and crc helper for the meter response decoder
`default_nettype none
package mmrd_pkg;

  localparam int FRAME_LENGTH  = 25;
  localparam int PAYLOAD_FIRST = 3;
  localparam int PAYLOAD_COUNT = FRAME_LENGTH - 5;
  localparam int CRC_LO_POS    = FRAME_LENGTH - 2;
  localparam int CRC_HI_POS    = FRAME_LENGTH - 1;
  localparam int CNT_W         = $clog2(FRAME_LENGTH);
  localparam int PAY_IDX_W     = $clog2(PAYLOAD_COUNT);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  // byte-wide reflected crc-16 update, unrolled over the eight bits
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/modbus_meter_response_decoder_unit.sv
// meter response frame decoder: crc check and measurement extraction
//
// Input channel: one request per cycle while in_stall is low; in_mode 0 carries
// a received frame byte in in_data_byte, in_mode 1 marks a receive timeout. A
// request is taken at a rising edge with in_valid high and in_stall low.
// A frame is 25 bytes: header, 20 payload bytes, crc low then crc high. The
// last byte gives one result: status 0 with the measurements if the crc-16
// over the first 23 bytes matches, otherwise status 1 with zero fields.
// A timeout gives status 2 with zero fields and restarts the frame count.
// A result reaches out_valid through the input register and then the result
// register, once the request that caused it is taken.
// Throughput: one request per cycle while in_stall is low; the crc update is
// a single byte-wide xor network from the input register to state registers.
// Reset (rst_n low, synchronous) empties both registers, clears the byte count
// and loads the crc with FFFF. When out_stall is high the result is held, and
// in_stall rises only once a held request would need the occupied result
// register; requests that give no result keep flowing.
`default_nettype none
module modbus_meter_response_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_voltage_x10,
  output logic [31:0]      out_current_x1000,
  output logic [31:0]      out_power_x10,
  output logic [31:0]      out_energy_wh,
  output logic [15:0]      out_frequency_x10,
  output logic [15:0]      out_power_factor_x100,
  output logic [15:0]      out_alarm_word
);
  import mmrd_pkg::*;

  // input register
  logic                 s1_valid_r;
  logic                 s1_mode_r;
  logic [7:0]           s1_byte_r;

  // frame state
  logic [CNT_W-1:0]     byte_cnt_r, byte_cnt_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [7:0]           crc_lo_r;
  logic [7:0]           payload_r [PAYLOAD_COUNT];

  // result register
  logic                 out_valid_r;
  status_t              status_r, status_nxt;
  logic [15:0]          volt_r, freq_r, pf_r, alarm_r;
  logic [31:0]          curr_r, pwr_r, energy_r;

  logic                 res_en;
  logic                 out_free;
  logic                 s1_adv;
  logic                 pay_wr;
  logic [PAY_IDX_W-1:0] pay_idx;
  logic                 crc_ok;

  assign out_free = !out_valid_r || !out_stall;
  assign res_en   = (s1_mode_r == MODE_TIMEOUT) || (byte_cnt_r == CNT_W'(CRC_HI_POS));
  assign s1_adv   = s1_valid_r && (!res_en || out_free);
  assign in_stall = s1_valid_r && !s1_adv;

  assign crc_ok  = ({s1_byte_r, crc_lo_r} == crc_r);
  assign pay_idx = PAY_IDX_W'(byte_cnt_r - CNT_W'(PAYLOAD_FIRST));
  assign pay_wr  = s1_adv && (s1_mode_r == MODE_BYTE)
                   && (byte_cnt_r >= CNT_W'(PAYLOAD_FIRST))
                   && (byte_cnt_r < CNT_W'(PAYLOAD_FIRST + PAYLOAD_COUNT));

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    crc_nxt      = crc_r;
    if (res_en) begin
      byte_cnt_nxt = '0;
      crc_nxt      = CRC_INIT;
    end else begin
      byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
      if (byte_cnt_r < CNT_W'(CRC_LO_POS)) begin
        crc_nxt = crc_byte(crc_r, s1_byte_r);
      end
    end
  end

  always_comb begin
    if (s1_mode_r == MODE_TIMEOUT) begin
      status_nxt = ST_SHORT;
    end else if (crc_ok) begin
      status_nxt = ST_VALID;
    end else begin
      status_nxt = ST_CRC_ERR;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_data_byte;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      crc_r      <= CRC_INIT;
    end else if (s1_adv) begin
      byte_cnt_r <= byte_cnt_nxt;
      crc_r      <= crc_nxt;
    end
    if (s1_adv && (s1_mode_r == MODE_BYTE) && (byte_cnt_r == CNT_W'(CRC_LO_POS))) begin
      crc_lo_r <= s1_byte_r;
    end
    if (pay_wr) begin
      payload_r[pay_idx] <= s1_byte_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && res_en;
    end
    if (out_free && s1_valid_r && res_en) begin
      status_r <= status_nxt;
      if (status_nxt == ST_VALID) begin
        volt_r   <= {payload_r[0], payload_r[1]};
        curr_r   <= {payload_r[4], payload_r[5], payload_r[2], payload_r[3]};
        pwr_r    <= {payload_r[8], payload_r[9], payload_r[6], payload_r[7]};
        energy_r <= {payload_r[12], payload_r[13], payload_r[10], payload_r[11]};
        freq_r   <= {payload_r[14], payload_r[15]};
        pf_r     <= {payload_r[16], payload_r[17]};
        alarm_r  <= {payload_r[18], payload_r[19]};
      end else begin
        volt_r   <= '0;
        curr_r   <= '0;
        pwr_r    <= '0;
        energy_r <= '0;
        freq_r   <= '0;
        pf_r     <= '0;
        alarm_r  <= '0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_voltage_x10       = volt_r;
  assign out_current_x1000     = curr_r;
  assign out_power_x10         = pwr_r;
  assign out_energy_wh         = energy_r;
  assign out_frequency_x10     = freq_r;
  assign out_power_factor_x100 = pf_r;
  assign out_alarm_word        = alarm_r;

`ifndef NO_ASSERTIONS
  // byte count never runs past the crc high byte
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CNT_W'(CRC_HI_POS))
    else $error("byte count out of range");

  // a result always restarts the frame
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_en) |=> (byte_cnt_r == '0 && crc_r == CRC_INIT))
    else $error("frame not restarted after result");

  // failed frames carry zero measurements
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_VALID) |->
      (volt_r == '0 && curr_r == '0 && pwr_r == '0 && energy_r == '0
       && freq_r == '0 && pf_r == '0 && alarm_r == '0))
    else $error("non-zero fields on failed frame");

  // a held result is never overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(status_r) && $stable(curr_r)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// testbench for the meter response decoder: frames and timeouts checked against predicted results
`timescale 1ns / 1ps
module testbench;
  import mmrd_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [15:0] voltage;
    logic [31:0] current;
    logic [31:0] power;
    logic [31:0] energy;
    logic [15:0] frequency;
    logic [15:0] power_factor;
    logic [15:0] alarm;
  } meter_result_t;

  typedef logic [7:0] frame_t [FRAME_LENGTH];

  localparam int STALL_PCT      = 26;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  logic clk          = 1'b0;
  logic rst_n        = 1'b0;
  logic in_valid     = 1'b0;
  logic in_mode      = MODE_BYTE;
  logic [7:0] in_data_byte = 8'h00;
  logic out_stall    = 1'b0;

  wire        in_stall;
  wire        out_valid;
  wire [1:0]  out_status;
  wire [15:0] out_voltage_x10;
  wire [31:0] out_current_x1000;
  wire [31:0] out_power_x10;
  wire [31:0] out_energy_wh;
  wire [15:0] out_frequency_x10;
  wire [15:0] out_power_factor_x100;
  wire [15:0] out_alarm_word;

  logic [4:0]  rx_pos = '0;
  logic [15:0] rx_crc = CRC_INIT;
  logic [7:0]  rx_payload [PAYLOAD_COUNT];
  logic [7:0]  rx_crc_lo;

  meter_result_t pending_results[$];
  int mismatches   = 0;
  int quiet_cycles = 0;
  bit idle_on      = 1'b1;

  modbus_meter_response_decoder_unit u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_mode               (in_mode),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_voltage_x10       (out_voltage_x10),
    .out_current_x1000     (out_current_x1000),
    .out_power_x10         (out_power_x10),
    .out_energy_wh         (out_energy_wh),
    .out_frequency_x10     (out_frequency_x10),
    .out_power_factor_x100 (out_power_factor_x100),
    .out_alarm_word        (out_alarm_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void predict_response(logic mode, logic [7:0] data);
    meter_result_t r;
    logic [15:0]   rx;
    r = '0;
    if (mode == MODE_TIMEOUT) begin
      r.status = ST_SHORT;
      pending_results.push_back(r);
      rx_pos = '0;
      rx_crc = CRC_INIT;
    end else if (rx_pos < CRC_LO_POS) begin
      rx_crc = crc16_step(rx_crc, data);
      if (rx_pos >= PAYLOAD_FIRST) begin
        rx_payload[rx_pos - PAYLOAD_FIRST] = data;
      end
      rx_pos = rx_pos + 1'b1;
    end else if (rx_pos == CRC_LO_POS) begin
      rx_crc_lo = data;
      rx_pos    = rx_pos + 1'b1;
    end else begin
      rx = {data, rx_crc_lo};
      if (rx == rx_crc) begin
        r.status       = ST_VALID;
        r.voltage      = {rx_payload[0], rx_payload[1]};
        r.current      = {rx_payload[4], rx_payload[5], rx_payload[2], rx_payload[3]};
        r.power        = {rx_payload[8], rx_payload[9], rx_payload[6], rx_payload[7]};
        r.energy       = {rx_payload[12], rx_payload[13], rx_payload[10], rx_payload[11]};
        r.frequency    = {rx_payload[14], rx_payload[15]};
        r.power_factor = {rx_payload[16], rx_payload[17]};
        r.alarm        = {rx_payload[18], rx_payload[19]};
      end else begin
        r.status = ST_CRC_ERR;
      end
      pending_results.push_back(r);
      rx_pos = '0;
      rx_crc = CRC_INIT;
    end
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic send_request(logic mode, logic [7:0] data);
    while (idle_on && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_response(mode, data);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void seal_frame(ref frame_t f);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < CRC_LO_POS; i++) c = crc16_step(c, f[i]);
    f[CRC_LO_POS] = c[7:0];
    f[CRC_HI_POS] = c[15:8];
  endfunction

  task automatic send_frame(frame_t f, int n);
    for (int i = 0; i < n; i++) send_request(MODE_BYTE, f[i]);
  endtask

  task automatic send_random_frame(int kind);
    frame_t f;
    int     cut;
    for (int i = 0; i < FRAME_LENGTH; i++) f[i] = pick_byte();
    seal_frame(f);
    case (kind)
      // single bit error anywhere in the frame
      6, 7: begin
        cut = $urandom_range(CRC_HI_POS);
        f[cut] = f[cut] ^ (8'h01 << $urandom_range(7));
        send_frame(f, FRAME_LENGTH);
      end
      // frame cut short by a timeout
      8, 9: begin
        send_frame(f, $urandom_range(CRC_HI_POS));
        send_request(MODE_TIMEOUT, pick_byte());
      end
      default: send_frame(f, FRAME_LENGTH);
    endcase
  endtask

  task automatic test_timeout_empty_line();
    send_request(MODE_TIMEOUT, 8'hFF);
  endtask

  task automatic test_extreme_frame();
    frame_t f;
    f[0] = 8'hF8;
    f[1] = 8'h04;
    f[2] = 8'h14;
    for (int i = 0; i < PAYLOAD_COUNT; i++) begin
      f[PAYLOAD_FIRST + i] = (i < PAYLOAD_COUNT / 2) ? 8'h00 : 8'hFF;
    end
    seal_frame(f);
    send_frame(f, FRAME_LENGTH);
  endtask

  task automatic test_random_frames(int count);
    for (int n = 0; n < count; n++) begin
      send_random_frame($urandom_range(9));
      if (n % 8 == 7) begin
        wait_drained();
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int n = 0; n < 4; n++) send_random_frame(0);
    idle_on = 1'b1;
  endtask

  task automatic test_line_noise(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) begin
        send_request(MODE_TIMEOUT, 8'($urandom));
      end else begin
        send_request(MODE_BYTE, 8'($urandom));
      end
    end
    // realign the frame count
    send_request(MODE_TIMEOUT, 8'h00);
  endtask

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < STALL_PCT);
  end

  always @(posedge clk) begin
    meter_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_status), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_voltage_x10 !== want.voltage)
          report_mismatch("voltage", 32'(out_voltage_x10), 32'(want.voltage));
        if (out_current_x1000 !== want.current)
          report_mismatch("current", out_current_x1000, want.current);
        if (out_power_x10 !== want.power)
          report_mismatch("power", out_power_x10, want.power);
        if (out_energy_wh !== want.energy)
          report_mismatch("energy", out_energy_wh, want.energy);
        if (out_frequency_x10 !== want.frequency)
          report_mismatch("frequency", 32'(out_frequency_x10), 32'(want.frequency));
        if (out_power_factor_x100 !== want.power_factor)
          report_mismatch("power factor", 32'(out_power_factor_x100),
                          32'(want.power_factor));
        if (out_alarm_word !== want.alarm)
          report_mismatch("alarm", 32'(out_alarm_word), 32'(want.alarm));
      end
    end
  end

  // cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_timeout_empty_line();
    test_extreme_frame();
    test_random_frames(14);
    test_back_to_back();
    test_line_noise(120);
    test_random_frames(6);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_results.size() != 0) begin
      report_mismatch("missing result, status", '0, 32'(pending_results[0].status));
      void'(pending_results.pop_front());
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mmrd_pkg.sv
sv/modbus_meter_response_decoder_unit.sv
bench/testbench.sv
